### hdl/psd_pkg.sv
// Shared types and constants for the pairwise sequence score distance block.
package psd_pkg;

    localparam int ALPHABET_DEF  = 32;
    localparam int MAX_SITES_DEF = 65536;

    localparam int SYM_W   = 5;
    localparam int SCORE_W = 16;
    localparam int SUM_W   = 40;
    localparam int CNT_W   = 17;
    localparam int COUNT_CAP = 131071;

    // sum is never negative, so the quotient needs one bit less than the sum
    localparam int QUO_W = SUM_W - 1;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SCORE_W-1:0] DIST_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_SITE = 1'b1;

    typedef struct packed {
        logic             start;
        logic [QUO_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### hdl/psd_ram.sv
// Generic single-clock RAM, one write port and one read port, registered read.
module psd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/psd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module psd_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  psd_pkg::t_div_req        i_req,
    output psd_pkg::t_div_stat       o_stat,
    output logic [psd_pkg::QUO_W-1:0] o_quotient
);

    localparam int QW = psd_pkg::QUO_W;
    localparam int DW = psd_pkg::CNT_W;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;
    logic          w_geq;

    assign w_sh   = {r_rem, r_q[QW-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_geq  = !w_diff[DW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q    <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= CW'(QW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[QW-2:0], w_geq};
                r_rem <= w_geq ? w_diff[DW-1:0] : w_sh[DW-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_q;

endmodule

### hdl/pairwise_sequence_score_distance.sv
// Top level: score table, site accumulator, sequencer and per-pair divide.
//
// Input channel i_valid / o_stall carries one beat per item. i_func selects a
// table load (write i_score at row i_symbol_a, column i_symbol_b) or an
// alignment site (look up the pair score; a non-negative score is added to
// the running sum and the site counted). i_last on a site closes the pair.
// Output channel o_valid / i_stall carries one result beat per closed pair:
// distance (sum / sites, truncated, capped at 32767), sum, sites used and
// the no_sites flag (distance forced to 0).
// A load is written straight into the table; a site is a table read, then an add.
// A closing site then runs the restoring divider, one quotient bit per cycle,
// before the result is registered. The result sits in an output register; the
// block takes new items while it waits, but a further closing site holds until
// the pending beat is taken.
// Reset: a clearing pass writes zero to all ALPHABET*ALPHABET table entries,
// one per cycle, with o_stall high throughout.
module pairwise_sequence_score_distance #(
    parameter int ALPHABET  = psd_pkg::ALPHABET_DEF,
    parameter int MAX_SITES = psd_pkg::MAX_SITES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_func,
    input  logic [psd_pkg::SYM_W-1:0]         i_symbol_a,
    input  logic [psd_pkg::SYM_W-1:0]         i_symbol_b,
    input  logic signed [psd_pkg::SCORE_W-1:0] i_score,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [psd_pkg::SCORE_W-1:0] o_distance,
    output logic signed [psd_pkg::SUM_W-1:0]   o_score_sum,
    output logic [psd_pkg::CNT_W-1:0]         o_sites_used,
    output logic                              o_no_sites
);

    localparam int DEPTH = ALPHABET * ALPHABET;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = psd_pkg::SCORE_W;
    localparam int UW    = psd_pkg::SUM_W;
    localparam int NW    = psd_pkg::CNT_W;
    localparam int QW    = psd_pkg::QUO_W;
    localparam int CNT_LIM = (MAX_SITES > psd_pkg::COUNT_CAP) ? psd_pkg::COUNT_CAP
                                                              : MAX_SITES;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ACC   = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0] r_clr;
    logic [UW-1:0] r_sum;
    logic [NW-1:0] r_cnt;
    logic          r_inside;
    logic          r_last;
    logic          r_div_start;
    logic          r_out_valid;
    logic [SW-1:0] r_distance;
    logic [UW-1:0] r_score_sum;
    logic [NW-1:0] r_sites_used;
    logic          r_no_sites;

    logic          w_accept;
    logic          w_inside;
    logic [AW-1:0] w_idx;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [SW-1:0] w_wdata;
    logic [SW-1:0] w_rdata;
    logic [SW-1:0] w_s;
    logic [UW:0]   w_sum_ext;
    logic [UW-1:0] n_sum;
    logic          w_out_free;
    logic          w_dist_sat;

    psd_pkg::t_div_req  w_div_req;
    psd_pkg::t_div_stat w_div_stat;
    logic [QW-1:0]      w_quotient;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    assign w_inside = (int'(i_symbol_a) < ALPHABET) && (int'(i_symbol_b) < ALPHABET);
    assign w_idx    = AW'(int'(i_symbol_a) * ALPHABET + int'(i_symbol_b));

    // clearing pass owns the write port until it is through
    assign w_we    = (r_state == S_CLEAR) ||
                     (w_accept && (i_func == psd_pkg::FUNC_LOAD) && w_inside);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr : w_idx;
    assign w_wdata = (r_state == S_CLEAR) ? '0 : i_score;

    psd_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    // out-of-alphabet site scores zero
    assign w_s       = r_inside ? w_rdata : '0;
    assign w_sum_ext = {1'b0, r_sum} + {{(UW + 1 - SW){1'b0}}, w_s};
    assign n_sum     = (w_sum_ext > {1'b0, psd_pkg::SUM_MAX}) ? psd_pkg::SUM_MAX
                                                              : w_sum_ext[UW-1:0];

    assign w_div_req.start    = r_div_start;
    assign w_div_req.dividend = r_sum[QW-1:0];
    assign w_div_req.divisor  = r_cnt;

    psd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_dist_sat = |w_quotient[QW-1:SW-1];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept && (i_func == psd_pkg::FUNC_SITE)) n_state = S_ACC;
            end
            S_ACC: begin
                n_state = r_last ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (w_div_stat.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= 1'b0;
            // a new beat may replace the one taken at this edge
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_accept) begin
                r_inside <= w_inside;
                r_last   <= i_last;
            end
            if ((r_state == S_ACC) && !w_s[SW-1]) begin
                r_sum <= n_sum;
                if (int'(r_cnt) < CNT_LIM) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if ((r_state == S_ACC) && r_last) begin
                r_div_start <= 1'b1;
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_score_sum  <= r_sum;
                r_sites_used <= r_cnt;
                r_no_sites   <= (r_cnt == '0);
                if (r_cnt == '0) begin
                    r_distance <= '0;
                end else if (w_dist_sat) begin
                    r_distance <= psd_pkg::DIST_MAX;
                end else begin
                    r_distance <= {1'b0, w_quotient[SW-2:0]};
                end
                r_sum <= '0;
                r_cnt <= '0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_distance   = r_distance;
    assign o_score_sum  = r_score_sum;
    assign o_sites_used = r_sites_used;
    assign o_no_sites   = r_no_sites;

    a_no_sites_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_sites |-> (o_distance == '0) && (o_score_sum == '0))
        else $error("no_sites beat with non-zero distance or sum");

    a_dist_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_distance[SW-1] && !o_score_sum[UW-1])
        else $error("negative distance or sum on output");

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= CNT_LIM)
        else $error("site count beyond limit");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_div_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |=> w_div_stat.busy)
        else $error("divider not busy after start");

endmodule
